// File: rtl/motor_fault_monitor_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor fault monitor
// Shared concurrent property shapes, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FAULT_MONITOR_CORE_ASSERT_SVH
`define MOTOR_FAULT_MONITOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define MFM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MFM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mfm_pkg.sv
// ----------------------------------------------------------------------------
// mfm_pkg
// Types, constants and helper functions of the motor fault monitor.
// ----------------------------------------------------------------------------
package mfm_pkg;

  localparam int DEF_TICK_COUNTER_BITS = 16;
  localparam int DEF_SPEED_BITS        = 32;

  localparam int PERIOD_W    = 16;
  localparam int LIMIT16_W   = 16;
  localparam int SPD_LIMIT_W = 31;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int FAULT_W     = 7;

  // Bit positions in the error word.
  localparam int FB_OVERVOLT  = 0;
  localparam int FB_UNDERVOLT = 1;
  localparam int FB_OVERCURR  = 2;
  localparam int FB_RUNAWAY   = 3;
  localparam int FB_ENCODER   = 4;
  localparam int FB_OVERTEMP  = 5;
  localparam int FB_UNDERTEMP = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERVOLT_LIMIT  = 3'd0,
    REG_SPEED_ERR_LIMIT = 3'd1,
    REG_SPEED_PERIOD    = 3'd2,
    REG_ENCODER_PERIOD  = 3'd3,
    REG_VOLTAGE_PERIOD  = 3'd4,
    REG_TEMP_PERIOD     = 3'd5,
    REG_OVERTEMP_LIMIT  = 3'd6,
    REG_UNDERTEMP_LIMIT = 3'd7
  } cfg_reg_t;

  localparam logic [LIMIT16_W-1:0]   RST_OVERVOLT_LIMIT  = 16'd40000;
  localparam logic [SPD_LIMIT_W-1:0] RST_SPEED_ERR_LIMIT = 31'd40960;
  localparam logic [PERIOD_W-1:0]    RST_SPEED_PERIOD    = 16'd2;
  localparam logic [PERIOD_W-1:0]    RST_ENCODER_PERIOD  = 16'd1;
  localparam logic [PERIOD_W-1:0]    RST_VOLTAGE_PERIOD  = 16'd2;
  localparam logic [PERIOD_W-1:0]    RST_TEMP_PERIOD     = 16'd5;
  localparam logic [LIMIT16_W-1:0]   RST_OVERTEMP_LIMIT  = 16'd55893;
  localparam logic [LIMIT16_W-1:0]   RST_UNDERTEMP_LIMIT = 16'd0;

  typedef struct packed {
    logic [LIMIT16_W-1:0]   overvoltage_limit;
    logic [SPD_LIMIT_W-1:0] speed_error_limit;
    logic [PERIOD_W-1:0]    speed_check_period;
    logic [PERIOD_W-1:0]    encoder_check_period;
    logic [PERIOD_W-1:0]    voltage_check_period;
    logic [PERIOD_W-1:0]    temp_check_period;
    logic [LIMIT16_W-1:0]   overtemp_limit;
    logic [LIMIT16_W-1:0]   undertemp_limit;
  } cfg_regs_t;

  // Advance a decimation residue. It clears once it reaches the period
  // (a period of zero therefore behaves as one) or when its counter wraps.
  function automatic logic [PERIOD_W-1:0] bump_residue(
    input logic [PERIOD_W-1:0] res,
    input logic [PERIOD_W-1:0] period,
    input logic                wrapped
  );
    logic [PERIOD_W:0] inc;
    inc = {1'b0, res} + {{PERIOD_W{1'b0}}, 1'b1};
    if (wrapped || (inc >= {1'b0, period})) begin
      return '0;
    end
    return inc[PERIOD_W-1:0];
  endfunction

endpackage

// File: rtl/mfm_cfg_regs.sv
// ----------------------------------------------------------------------------
// mfm_cfg_regs
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
module mfm_cfg_regs
  import mfm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_regs_t             cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_OVERVOLT_LIMIT:  cfg_nxt.overvoltage_limit    = wr_data[LIMIT16_W-1:0];
        REG_SPEED_ERR_LIMIT: cfg_nxt.speed_error_limit    = wr_data[SPD_LIMIT_W-1:0];
        REG_SPEED_PERIOD:    cfg_nxt.speed_check_period   = wr_data[PERIOD_W-1:0];
        REG_ENCODER_PERIOD:  cfg_nxt.encoder_check_period = wr_data[PERIOD_W-1:0];
        REG_VOLTAGE_PERIOD:  cfg_nxt.voltage_check_period = wr_data[PERIOD_W-1:0];
        REG_TEMP_PERIOD:     cfg_nxt.temp_check_period    = wr_data[PERIOD_W-1:0];
        REG_OVERTEMP_LIMIT:  cfg_nxt.overtemp_limit       = wr_data[LIMIT16_W-1:0];
        REG_UNDERTEMP_LIMIT: cfg_nxt.undertemp_limit      = wr_data[LIMIT16_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overvoltage_limit    <= RST_OVERVOLT_LIMIT;
      cfg_r.speed_error_limit    <= RST_SPEED_ERR_LIMIT;
      cfg_r.speed_check_period   <= RST_SPEED_PERIOD;
      cfg_r.encoder_check_period <= RST_ENCODER_PERIOD;
      cfg_r.voltage_check_period <= RST_VOLTAGE_PERIOD;
      cfg_r.temp_check_period    <= RST_TEMP_PERIOD;
      cfg_r.overtemp_limit       <= RST_OVERTEMP_LIMIT;
      cfg_r.undertemp_limit      <= RST_UNDERTEMP_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/mfm_checks.sv
// ----------------------------------------------------------------------------
// mfm_checks
// Decimation counters, fault checks and the sticky fault word.
// ----------------------------------------------------------------------------
module mfm_checks
  import mfm_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = DEF_TICK_COUNTER_BITS,
  parameter int SPEED_BITS        = DEF_SPEED_BITS
)(
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfg_regs_t                    cfg,
  input  logic                         step,
  input  logic                         action,
  input  logic [15:0]                  bus_voltage_sample,
  input  logic                         current_fault_event,
  input  logic signed [SPEED_BITS-1:0] speed_target,
  input  logic signed [SPEED_BITS-1:0] speed_feedback,
  input  logic [31:0]                  rotor_angle,
  input  logic                         direction_cw,
  input  logic [15:0]                  temp_sample,
  output logic [FAULT_W-1:0]           fault_word_nxt
);

  localparam int DIFF_W = (SPEED_BITS + 1 > SPD_LIMIT_W + 1) ? SPEED_BITS + 1
                                                              : SPD_LIMIT_W + 1;

  // The voltage, speed and encoder counters of the scheme advance on the
  // same calls, so one tick counter serves all three.
  logic [TICK_COUNTER_BITS-1:0] tick_count_r, tick_count_nxt;
  logic [TICK_COUNTER_BITS-1:0] temp_count_r, temp_count_nxt;
  logic [PERIOD_W-1:0]          volt_res_r, volt_res_nxt;
  logic [PERIOD_W-1:0]          speed_res_r, speed_res_nxt;
  logic [PERIOD_W-1:0]          enc_res_r, enc_res_nxt;
  logic [PERIOD_W-1:0]          temp_res_r, temp_res_nxt;
  logic [FAULT_W-1:0]           fault_r, fault_nxt;

  logic                         tick_wrap, temp_wrap;
  logic signed [DIFF_W-1:0]     tgt_x, fb_x, diff, lim_x;
  logic                         runaway;

  assign tgt_x   = DIFF_W'(speed_target);
  assign fb_x    = DIFF_W'(speed_feedback);
  assign diff    = tgt_x - fb_x;
  assign lim_x   = DIFF_W'(cfg.speed_error_limit);
  assign runaway = (diff > lim_x) || (diff < -lim_x);

  assign tick_wrap = &tick_count_r;
  assign temp_wrap = &temp_count_r;

  always_comb begin
    tick_count_nxt = tick_count_r;
    temp_count_nxt = temp_count_r;
    volt_res_nxt   = volt_res_r;
    speed_res_nxt  = speed_res_r;
    enc_res_nxt    = enc_res_r;
    temp_res_nxt   = temp_res_r;
    fault_nxt      = fault_r;
    if (!action) begin
      tick_count_nxt = tick_count_r + 1'b1;
      volt_res_nxt   = bump_residue(volt_res_r, cfg.voltage_check_period, tick_wrap);
      speed_res_nxt  = bump_residue(speed_res_r, cfg.speed_check_period, tick_wrap);
      enc_res_nxt    = bump_residue(enc_res_r, cfg.encoder_check_period, tick_wrap);
      if ((volt_res_nxt == '0) && (bus_voltage_sample > cfg.overvoltage_limit)) begin
        fault_nxt[FB_OVERVOLT] = 1'b1;
      end
      // The overcurrent latch and its fault bit are both sticky, so the bit
      // itself holds the latch.
      if (current_fault_event) begin
        fault_nxt[FB_OVERCURR] = 1'b1;
      end
      if ((speed_res_nxt == '0) && runaway) begin
        fault_nxt[FB_RUNAWAY] = 1'b1;
      end
      if ((enc_res_nxt == '0) && (rotor_angle == '0) && (speed_target != '0) &&
          direction_cw) begin
        fault_nxt[FB_ENCODER] = 1'b1;
      end
    end else begin
      temp_count_nxt = temp_count_r + 1'b1;
      temp_res_nxt   = bump_residue(temp_res_r, cfg.temp_check_period, temp_wrap);
      if (temp_res_nxt == '0) begin
        if (temp_sample > cfg.overtemp_limit) begin
          fault_nxt[FB_OVERTEMP] = 1'b1;
        end else if (temp_sample < cfg.undertemp_limit) begin
          fault_nxt[FB_UNDERTEMP] = 1'b1;
        end
      end
    end
    // The minimum bus voltage is zero, so undervoltage can never be seen.
    fault_nxt[FB_UNDERVOLT] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      temp_count_r <= '0;
      volt_res_r   <= '0;
      speed_res_r  <= '0;
      enc_res_r    <= '0;
      temp_res_r   <= '0;
      fault_r      <= '0;
    end else if (step) begin
      tick_count_r <= tick_count_nxt;
      temp_count_r <= temp_count_nxt;
      volt_res_r   <= volt_res_nxt;
      speed_res_r  <= speed_res_nxt;
      enc_res_r    <= enc_res_nxt;
      temp_res_r   <= temp_res_nxt;
      fault_r      <= fault_nxt;
    end
  end

  assign fault_word_nxt = fault_nxt;

endmodule

// File: rtl/motor_fault_monitor_core.sv
// ----------------------------------------------------------------------------
// motor_fault_monitor_core
// Sticky fault word for a motor drive, one result item per input item.
// ----------------------------------------------------------------------------
// Usage: each item on the in_ channel is a protection tick (in_tuser low) or
// a temperature sample (in_tuser high). A tick latches the overcurrent event
// and runs the overvoltage, runaway and encoder checks, each on its own
// decimation; a sample runs the temperature check on its decimation.
// Every item yields exactly one item on the out_ channel carrying the error
// word after that item. Fault bits stay set until reset.
// The item passes one input register, then the checks and the result
// register; out_tvalid rises when the item moves into the result register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the single pass of compare logic between those two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; in_tready then falls until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, clears all counters
// and faults and loads the default limits and periods. The cfg_ channel is
// always ready and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module motor_fault_monitor_core
  import mfm_pkg::*;
#(
  parameter int TICK_COUNTER_BITS = DEF_TICK_COUNTER_BITS,
  parameter int SPEED_BITS        = DEF_SPEED_BITS
)(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: bus_voltage_sample, current_fault_event, speed_target,
  // speed_feedback, rotor_angle, direction_cw, temp_sample, zero fill.
  input  logic [((66 + 2*SPEED_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // Fields from bit 0: action.
  input  logic                  in_tuser,
  // Result item stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: error_word, zero fill.
  output logic [7:0]            out_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TDATA_W  = ((66 + 2*SPEED_BITS + 7) / 8) * 8;
  localparam int OFF_BUS  = 0;
  localparam int OFF_EVT  = OFF_BUS + 16;
  localparam int OFF_TGT  = OFF_EVT + 1;
  localparam int OFF_FB   = OFF_TGT + SPEED_BITS;
  localparam int OFF_ANG  = OFF_FB + SPEED_BITS;
  localparam int OFF_CW   = OFF_ANG + 32;
  localparam int OFF_TEMP = OFF_CW + 1;

  cfg_regs_t cfg;

  // Input register stage.
  logic               s1_valid_r, s1_valid_nxt;
  logic [TDATA_W-1:0] s1_data_r;
  logic               s1_action_r;

  // Result register stage.
  logic               out_valid_r, out_valid_nxt;
  logic [FAULT_W-1:0] out_word_r;
  logic [FAULT_W-1:0] fault_word_nxt;

  logic in_fire;
  logic advance;

  // The held item moves into the result register when that register is
  // empty or is being emptied in this cycle.
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r   <= in_tdata;
      s1_action_r <= in_tuser;
    end
    if (advance) begin
      out_word_r <= fault_word_nxt;
    end
  end

  mfm_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  mfm_checks #(
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS),
    .SPEED_BITS        (SPEED_BITS)
  ) u_checks (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .step                (advance),
    .action              (s1_action_r),
    .bus_voltage_sample  (s1_data_r[OFF_BUS +: 16]),
    .current_fault_event (s1_data_r[OFF_EVT]),
    .speed_target        (s1_data_r[OFF_TGT +: SPEED_BITS]),
    .speed_feedback      (s1_data_r[OFF_FB +: SPEED_BITS]),
    .rotor_angle         (s1_data_r[OFF_ANG +: 32]),
    .direction_cw        (s1_data_r[OFF_CW]),
    .temp_sample         (s1_data_r[OFF_TEMP +: 16]),
    .fault_word_nxt      (fault_word_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_word_r};

  // Assertions.
  `include "motor_fault_monitor_core_assert.svh"

  // Faults are sticky: a new result never drops a bit of the one before.
  `MFM_ASSERT_NXT(a_faults_sticky, out_valid_r && advance, (out_word_r & $past(out_word_r)) == $past(out_word_r), "fault bit cleared between results")

  // An item held at the input is never lost while the result side stalls.
  `MFM_ASSERT_NXT(a_s1_held, s1_valid_r && !advance, s1_valid_r, "held item dropped")

  // The undervoltage bit can never be raised.
  `MFM_ASSERT_IMP(a_no_undervolt, out_valid_r, !out_word_r[FB_UNDERVOLT], "undervoltage bit set")

  // A stalled result keeps its value until it is taken.
  `MFM_ASSERT_NXT(a_out_hold, out_valid_r && !out_tready, out_word_r == $past(out_word_r), "stalled result changed")

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for motor_fault_monitor_core. Items are driven on the
// in_ stream and every result item is checked against a cycle-free model of
// the sticky fault word, kept inside the bench. Runs a short table of
// boundary items, then random items over several register settings,
// including a steady run with no idling on either side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mfm_pkg::*;

  localparam int IN_W          = 136;
  localparam int PHASE_COUNT   = 9;
  localparam int PHASE_HOLD    = 3;
  localparam int PHASE_STEADY  = 7;
  localparam int STEADY_ITEMS  = 100;
  localparam int HOLD_CYCLES   = 300;

  // One input item: action selects a protection tick (0) or a temperature
  // sample (1).
  typedef struct packed {
    logic               action;
    logic [15:0]        bus;
    logic               cur_evt;
    logic signed [31:0] tgt;
    logic signed [31:0] fb;
    logic [31:0]        angle;
    logic               cw;
    logic [15:0]        temp;
  } mon_item_t;

  // A directed row; want is the typed-in error word, or -1 where the
  // prediction decides.
  typedef struct packed {
    mon_item_t it;
    int        want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Idling on both sides is enabled by gaps_on. A change of hold_stamp asks
  // the receiver for one long hold-off.
  logic gaps_on = 1'b1;
  int   hold_stamp = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   error_count = 0;

  // Model state: register copy, decimation counters and sticky faults.
  cfg_regs_t          limits_now;
  logic [15:0]        tick_cnt, temp_cnt;
  logic [15:0]        volt_res, spd_res, enc_res, temp_res;
  logic [FAULT_W-1:0] fault_word;
  logic               oc_latch;

  logic [FAULT_W-1:0] expected_words [$];

  motor_fault_monitor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Boundary items under the reset settings. Voltage and speed are checked
  // on even ticks, the encoder on every tick and temperature on every fifth
  // sample, so the huge values land on ticks where their check is skipped
  // and the checked ones sit exactly on their limits.
  dir_row_t directed_rows [0:19] = '{
    '{'{1'b0, 16'd0,     1'b0, 32'sd0,          32'sd0,          32'd0,         1'b0, 16'd0},
      0},
    '{'{1'b0, 16'd40000, 1'b0, 32'sd40960,      32'sd0,          32'hFFFF_FFFF, 1'b1, 16'hFFFF},
      0},
    '{'{1'b0, 16'hFFFF,  1'b0, 32'sh8000_0000,  32'sh7FFF_FFFF,  32'd0,         1'b0, 16'd0},
      0},
    '{'{1'b0, 16'd0,     1'b0, 32'sd0,          -32'sd40960,     32'd0,         1'b1, 16'd0},
      0},
    '{'{1'b0, 16'hFFFF,  1'b0, 32'sh7FFF_FFFF,  32'sh8000_0000,  32'd1,         1'b1, 16'd0},
      0},
    '{'{1'b0, 16'd39999, 1'b0, 32'sh8000_0000,  32'sh8000_0000,  32'h8000_0000, 1'b1, 16'd0},
      0},
    '{'{1'b0, 16'd0,     1'b0, 32'sh7FFF_FFFF,  32'sh7FFF_FFFF,  32'd0,         1'b0, 16'd0},
      0},
    '{'{1'b0, 16'd40000, 1'b0, -32'sd40960,     32'sd0,          32'h5555_5555, 1'b0, 16'd0},
      0},
    // A sample with every other field at its top, overcurrent included,
    // must leave the word alone.
    '{'{1'b1, 16'hFFFF,  1'b1, -32'sd1,         -32'sd1,         32'hFFFF_FFFF, 1'b1, 16'hFFFF},
      0},
    '{'{1'b1, 16'd0,     1'b0, 32'sd0,          32'sd0,          32'd0,         1'b0, 16'd0},
      0},
    '{'{1'b1, 16'd0,     1'b0, 32'sd0,          32'sd0,          32'd0,         1'b0, 16'hFFFF},
      0},
    '{'{1'b1, 16'd0,     1'b0, 32'sd0,          32'sd0,          32'd0,         1'b0, 16'd0},
      0},
    '{'{1'b1, 16'd0,     1'b0, 32'sd0,          32'sd0,          32'd0,         1'b0, 16'd55893},
      0},
    '{'{1'b0, 16'd40001, 1'b0, 32'sd0,          32'sh7FFF_FFFF,  32'd0,         1'b1, 16'h1234},
      -1},
    '{'{1'b0, 16'd40000, 1'b0, 32'sd100,        -32'sd40860,     32'd5,         1'b1, 16'd0},
      -1},
    '{'{1'b1, 16'd0,     1'b0, 32'sd0,          32'sd0,          32'd0,         1'b0, 16'hFFFF},
      -1},
    '{'{1'b1, 16'd0,     1'b0, 32'sd0,          32'sd0,          32'd0,         1'b0, 16'd60000},
      -1},
    '{'{1'b1, 16'd0,     1'b0, 32'sd0,          32'sd0,          32'd0,         1'b0, 16'd55894},
      -1},
    '{'{1'b1, 16'd0,     1'b0, 32'sd0,          32'sd0,          32'd0,         1'b0, 16'd65000},
      -1},
    '{'{1'b1, 16'd0,     1'b0, 32'sd0,          32'sd0,          32'd0,         1'b0, 16'd1},
      -1}
  };

  // A residue steps on each call of its kind and clears when it reaches its
  // period (so a zero period acts as one) or when its counter has wrapped.
  function automatic logic [15:0] step_residue(input logic [15:0] res,
                                               input logic [15:0] period,
                                               input logic        wrapped);
    logic [16:0] inc;
    inc = {1'b0, res} + 17'd1;
    if (wrapped || inc >= {1'b0, period}) begin
      return '0;
    end
    return inc[15:0];
  endfunction

  // Advances the model by one item and returns the error word after it.
  function automatic logic [FAULT_W-1:0] next_fault_word(input mon_item_t it);
    longint gap;
    if (!it.action) begin
      tick_cnt = tick_cnt + 16'd1;
      volt_res = step_residue(volt_res, limits_now.voltage_check_period, tick_cnt == '0);
      if (volt_res == '0 && it.bus > limits_now.overvoltage_limit) begin
        fault_word[FB_OVERVOLT] = 1'b1;
      end
      if (it.cur_evt) begin
        oc_latch = 1'b1;
      end
      if (oc_latch) begin
        fault_word[FB_OVERCURR] = 1'b1;
      end
      spd_res = step_residue(spd_res, limits_now.speed_check_period, tick_cnt == '0);
      enc_res = step_residue(enc_res, limits_now.encoder_check_period, tick_cnt == '0);
      if (spd_res == '0) begin
        gap = longint'(it.tgt) - longint'(it.fb);
        if (gap < 0) begin
          gap = -gap;
        end
        if (gap > longint'({1'b0, limits_now.speed_error_limit})) begin
          fault_word[FB_RUNAWAY] = 1'b1;
        end
      end
      if (enc_res == '0 && it.angle == '0 && it.tgt != '0 && it.cw) begin
        fault_word[FB_ENCODER] = 1'b1;
      end
    end else begin
      temp_cnt = temp_cnt + 16'd1;
      temp_res = step_residue(temp_res, limits_now.temp_check_period, temp_cnt == '0);
      if (temp_res == '0) begin
        if (it.temp > limits_now.overtemp_limit) begin
          fault_word[FB_OVERTEMP] = 1'b1;
        end else if (it.temp < limits_now.undertemp_limit) begin
          fault_word[FB_UNDERTEMP] = 1'b1;
        end
      end
    end
    return fault_word;
  endfunction

  // A protection tick that mostly stays inside every limit. Roughly one in
  // `odds` draws breaks one limit, or makes the whole item noise.
  function automatic mon_item_t make_tick(input int unsigned odds);
    mon_item_t it;
    longint    d;
    longint    f;
    it = '0;
    it.temp = 16'($urandom);
    it.cw = 1'($urandom);
    if ($urandom_range(0, odds) == 0) begin
      it.bus = 16'($urandom);
      it.cur_evt = 1'($urandom);
      it.tgt = $urandom;
      it.fb = $urandom;
      it.angle = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
      return it;
    end
    it.bus = ($urandom_range(0, odds) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(0, limits_now.overvoltage_limit));
    it.cur_evt = ($urandom_range(0, odds) == 0);
    it.tgt = ($urandom_range(0, 7) == 0) ? 32'sd0 : $urandom;
    if ($urandom_range(0, odds) == 0) begin
      it.fb = $urandom;
    end else begin
      // Feedback within the allowed distance of the target, kept in range.
      d = longint'($urandom_range(0, limits_now.speed_error_limit));
      if ($urandom_range(0, 1) == 1) begin
        d = -d;
      end
      f = longint'(it.tgt) - d;
      if (f > 64'sd2147483647 || f < -64'sd2147483648) begin
        f = longint'(it.tgt) + d;
      end
      it.fb = f[31:0];
    end
    it.angle = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
    if (it.angle == '0 && it.tgt != '0 && $urandom_range(0, odds) != 0) begin
      it.cw = 1'b0;
    end
    return it;
  endfunction

  // A temperature sample: every unused field is random, the reading mostly
  // lies between the two limits.
  function automatic mon_item_t make_sample(input int unsigned odds);
    mon_item_t it;
    it = {1'b1, 16'($urandom), 1'($urandom), 32'($urandom), 32'($urandom),
          32'($urandom), 1'($urandom), 16'($urandom)};
    if ($urandom_range(0, odds) != 0 &&
        limits_now.undertemp_limit <= limits_now.overtemp_limit) begin
      it.temp = 16'($urandom_range(limits_now.undertemp_limit, limits_now.overtemp_limit));
    end
    return it;
  endfunction

  function automatic logic [15:0] pick_period();
    if ($urandom_range(0, 9) == 0) begin
      return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
    end
    return 16'($urandom_range(1, 9));
  endfunction

  // Register settings of each random phase. The period drop from nine to
  // two leaves residues above the new period; the steady phase mixes
  // periods of three to seven.
  function automatic cfg_regs_t phase_settings(input int p);
    cfg_regs_t s;
    case (p)
      0: s = '{16'd50000, 31'd1000000, 16'd3, 16'd4, 16'd1, 16'd2, 16'd60000, 16'd1000};
      1: s = '{16'hFFFF, 31'h7FFF_FFFF, 16'd0, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0};
      2: s = '{16'd45000, 31'd50000, 16'd9, 16'd9, 16'd9, 16'd9, 16'd58000, 16'd2000};
      3: s = '{16'd45000, 31'd50000, 16'd2, 16'd2, 16'd2, 16'd2, 16'd58000, 16'd2000};
      PHASE_STEADY: s = '{16'd60000, 31'd100000, 16'd6, 16'd5, 16'd7, 16'd3, 16'd60000,
                          16'd100};
      PHASE_COUNT - 1: s = '{16'd0, 31'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'hFFFF};
      default: begin
        s.overvoltage_limit    = 16'($urandom_range(30000, 65535));
        s.speed_error_limit    = 31'($urandom_range(1000, 32'h0100_0000));
        s.speed_check_period   = pick_period();
        s.encoder_check_period = pick_period();
        s.voltage_check_period = pick_period();
        s.temp_check_period    = pick_period();
        s.overtemp_limit       = 16'($urandom_range(40000, 65535));
        s.undertemp_limit      = 16'($urandom_range(0, 20000));
      end
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s: got %02h, expected %02h", $time, what, got, want);
    error_count++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic apply_settings(input cfg_regs_t s);
    write_reg(REG_OVERVOLT_LIMIT,  {16'd0, s.overvoltage_limit});
    write_reg(REG_SPEED_ERR_LIMIT, {1'b0, s.speed_error_limit});
    write_reg(REG_SPEED_PERIOD,    {16'd0, s.speed_check_period});
    write_reg(REG_ENCODER_PERIOD,  {16'd0, s.encoder_check_period});
    write_reg(REG_VOLTAGE_PERIOD,  {16'd0, s.voltage_check_period});
    write_reg(REG_TEMP_PERIOD,     {16'd0, s.temp_check_period});
    write_reg(REG_OVERTEMP_LIMIT,  {16'd0, s.overtemp_limit});
    write_reg(REG_UNDERTEMP_LIMIT, {16'd0, s.undertemp_limit});
    cfg_valid <= 1'b0;
    limits_now = s;
  endtask

  // Offers one item, possibly after idle cycles, and returns at the
  // clock edge where it was taken. Valid stays high for a following item.
  task automatic offer_item(input mon_item_t it, input int want);
    logic [FAULT_W-1:0] word;
    while (gaps_on && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    word = next_fault_word(it);
    expected_words.push_back((want < 0) ? word : want[FAULT_W-1:0]);
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {6'd0, it.temp, it.cw, it.angle, it.fb, it.tgt, it.cur_evt, it.bus};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
  endtask

  // Stops offering and waits until every result item has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_stamp != hold_seen) begin
      hold_seen  <= hold_stamp;
      hold_left  <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(gaps_on && $urandom_range(0, 99) < 16);
    end
  end

  // Result checker: each result item is matched against the oldest
  // expected word; the fill bit above the word must stay zero.
  always @(posedge clk) begin
    logic [FAULT_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result item with nothing expected", out_tdata, 8'h00);
      end else begin
        want = expected_words.pop_front();
        if (out_tdata !== {1'b0, want}) begin
          report_mismatch("error word", out_tdata, {1'b0, want});
        end
      end
    end
  end

  initial begin
    mon_item_t it;
    int        n_items;

    limits_now = '{RST_OVERVOLT_LIMIT, RST_SPEED_ERR_LIMIT, RST_SPEED_PERIOD,
                   RST_ENCODER_PERIOD, RST_VOLTAGE_PERIOD, RST_TEMP_PERIOD,
                   RST_OVERTEMP_LIMIT, RST_UNDERTEMP_LIMIT};
    tick_cnt   = '0;
    temp_cnt   = '0;
    volt_res   = '0;
    spd_res    = '0;
    enc_res    = '0;
    temp_res   = '0;
    fault_word = '0;
    oc_latch   = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table first, straight out of reset with the default settings.
    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].it, directed_rows[i].want);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // Registers are only written with nothing in flight.
      wait_drained();
      apply_settings(phase_settings(p));
      if (p == PHASE_STEADY) begin
        // A long run without idling on either side.
        gaps_on <= 1'b0;
        for (int n = 0; n < STEADY_ITEMS; n++) begin
          if ($urandom_range(0, 1) == 0) begin
            it = make_tick(500);
          end else begin
            it = make_sample(500);
          end
          offer_item(it, -1);
        end
        gaps_on <= 1'b1;
      end else begin
        n_items = (p == PHASE_COUNT - 1) ? 150 : 200;
        for (int n = 0; n < n_items; n++) begin
          // Starve the output for a while so the block fills and stalls.
          if (p == PHASE_HOLD && n == 30) begin
            hold_stamp <= hold_stamp + 1;
          end
          if ($urandom_range(0, 2) == 0) begin
            it = make_sample((p == PHASE_COUNT - 1) ? 20 : 500);
          end else begin
            it = make_tick((p == PHASE_COUNT - 1) ? 20 : 500);
          end
          offer_item(it, -1);
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin
    #8ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: motor_fault_monitor_core.f
+incdir+rtl
rtl/mfm_pkg.sv
rtl/mfm_cfg_regs.sv
rtl/mfm_checks.sv
rtl/motor_fault_monitor_core.sv
tb/tb.sv
